>>> sv/scfl_pkg.sv
// Package for the size-class free-list allocator: constants, payload types,
// command types and the back-end state enum. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package scfl_pkg;

    localparam int HEAP_BYTES_DEF      = 65536;
    localparam int NUM_CLASSES_DEF     = 254;
    localparam int HEADER_BYTES_DEF    = 16;
    localparam int MAX_CLASS_BYTES_DEF = 8096;
    localparam int ALIGN_BYTES         = 8;
    localparam int SLOT_BYTES          = 16;

    localparam logic       FUNC_ALLOC = 1'b0;
    localparam logic       FUNC_FREE  = 1'b1;
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERSIZE  = 2'd1;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

    typedef struct packed {
        logic        func;
        logic [15:0] request_bytes;
        logic [15:0] block_offset;
    } req_t;

    typedef struct packed {
        logic [15:0] data_offset;
        logic [1:0]  status;
    } rsp_t;

    // Classified command between front and back end.
    // kind: 0 alloc, 1 free, 2 immediate result (oversize or ignored free).
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_DONE  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  cls;
        logic [16:0] slot;
        logic [12:0] size32;
        logic [1:0]  status;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LINK,
        ST_FREE_RD,
        ST_FREE_WR
    } back_state_t;

endpackage
`default_nettype wire

>>> sv/scfl_if.sv
// Valid/ready channel interfaces for the allocator request and result.
// Depends on scfl_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface scfl_req_if;
    logic               valid;
    logic               ready;
    scfl_pkg::req_t     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface scfl_rsp_if;
    logic               valid;
    logic               ready;
    scfl_pkg::rsp_t     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> sv/scfl_front.sv
// Front end: accepts requests, computes the size class or slot, and
// registers the classified command. Depends on scfl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scfl_front #(
    parameter int HEAP_BYTES      = scfl_pkg::HEAP_BYTES_DEF,
    parameter int NUM_CLASSES     = scfl_pkg::NUM_CLASSES_DEF,
    parameter int HEADER_BYTES    = scfl_pkg::HEADER_BYTES_DEF,
    parameter int MAX_CLASS_BYTES = scfl_pkg::MAX_CLASS_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    scfl_req_if.sink           req,
    output scfl_pkg::cmd_t     cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_ready
);
    import scfl_pkg::*;

    localparam int PAD = (HEADER_BYTES <= ALIGN_BYTES) ? ALIGN_BYTES :
        ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int SLOTS = HEAP_BYTES / SLOT_BYTES;

    cmd_t        cmd_reg;
    logic        valid_reg;
    cmd_t        cmd_next;
    logic [16:0] total;
    logic [16:0] sub;
    logic [11:0] cls_w;

    always_comb
    begin
        cmd_next = '0;
        total = {1'b0, req.payload.request_bytes} + 17'(PAD);
        cls_w = (total <= 17'd16) ? 12'd0 : 12'((total + 17'd31) >> 5);
        sub = {1'b0, req.payload.block_offset} - 17'(PAD);
        if (req.payload.func == FUNC_ALLOC)
        begin
            cmd_next.cls = cls_w[7:0];
            cmd_next.size32 = (cls_w == 12'd0) ? 13'd16 : {cls_w[7:0], 5'd0};
            if (total > 17'(MAX_CLASS_BYTES) || cls_w >= 12'(NUM_CLASSES))
            begin
                cmd_next.kind = CMD_DONE;
                cmd_next.status = STATUS_OVERSIZE;
            end
            else
            begin
                cmd_next.kind = CMD_ALLOC;
            end
        end
        else
        begin
            cmd_next.slot = 17'(sub[16:4]);
            if (req.payload.block_offset < 16'(PAD) || 32'(sub[16:4]) >= SLOTS)
                cmd_next.kind = CMD_DONE;
            else
                cmd_next.kind = CMD_FREE;
        end
    end

    assign req.ready = !valid_reg || cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (req.ready)
            valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
            cmd_reg <= cmd_next;
    end

    assign cmd = cmd_reg;
    assign cmd_valid = valid_reg;
endmodule
`default_nettype wire

>>> sv/scfl_back.sv
// Back end: free-list heads, per-slot class and link memories, bump
// allocation and the result register. Depends on scfl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scfl_back #(
    parameter int HEAP_BYTES      = scfl_pkg::HEAP_BYTES_DEF,
    parameter int NUM_CLASSES     = scfl_pkg::NUM_CLASSES_DEF,
    parameter int HEADER_BYTES    = scfl_pkg::HEADER_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [16:0]   heap_limit,
    input  scfl_pkg::cmd_t     cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    scfl_rsp_if.source         rsp
);
    import scfl_pkg::*;

    localparam int PAD = (HEADER_BYTES <= ALIGN_BYTES) ? ALIGN_BYTES :
        ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int SLOTS = HEAP_BYTES / SLOT_BYTES;
    localparam int SW = $clog2(SLOTS);
    localparam int HW = $clog2(SLOTS + 1);
    localparam int CW = $clog2(NUM_CLASSES);
    localparam int BW = $clog2(HEAP_BYTES + 1) + 1;

    logic [HW-1:0] heads_mem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] head_ok_reg;
    logic [7:0]    class_mem [SLOTS];
    logic [HW-1:0] link_mem  [SLOTS];

    back_state_t   state_reg, state_next;
    cmd_t          cur_reg;
    logic [BW-1:0] bump_reg;
    logic [HW-1:0] head_rd_reg;
    logic [HW-1:0] link_rd_reg;
    logic [7:0]    class_rd_reg;
    logic          rsp_valid_reg;
    rsp_t          rsp_reg;

    logic          load, head_we, link_we, class_we, bump_we, rsp_load;
    logic [CW-1:0] head_idx;
    logic [HW-1:0] head_wdata;
    logic [SW-1:0] slot_idx;
    rsp_t          rsp_next;
    logic [BW-1:0] lim;
    logic [HW-1:0] head_val;

    assign slot_idx = (state_reg == ST_IDLE) ? cmd.slot[SW-1:0] : cur_reg.slot[SW-1:0];
    assign lim = (heap_limit > 17'(HEAP_BYTES)) ? BW'(HEAP_BYTES) : BW'(heap_limit);
    assign head_val = head_ok_reg[head_idx] ? head_rd_reg : '0;
    assign cmd_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        load = 1'b0; head_we = 1'b0; link_we = 1'b0; class_we = 1'b0;
        bump_we = 1'b0; rsp_load = 1'b0; rsp_next = '0;
        head_idx = CW'(cur_reg.cls); head_wdata = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    load = 1'b1;
                    case (cmd.kind)
                        CMD_ALLOC: state_next = ST_READ;
                        CMD_FREE:  state_next = ST_FREE_RD;
                        default:
                        begin
                            rsp_load = 1'b1;
                            rsp_next.status = cmd.status;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (head_val != '0)
                    state_next = ST_LINK;
                else
                begin
                    state_next = ST_IDLE;
                    rsp_load = 1'b1;
                    if (bump_reg + BW'(cur_reg.size32) > lim)
                        rsp_next.status = STATUS_EXHAUSTED;
                    else
                    begin
                        class_we = 1'b1;
                        bump_we = 1'b1;
                        rsp_next.data_offset = 16'(bump_reg + BW'(PAD));
                    end
                end
            end
            ST_LINK:
            begin
                state_next = ST_IDLE;
                rsp_load = 1'b1;
                head_we = 1'b1;
                head_wdata = link_rd_reg;
                rsp_next.data_offset = 16'(((32'(head_val) - 1) * SLOT_BYTES) + PAD);
            end
            ST_FREE_RD:
                state_next = ST_FREE_WR;
            ST_FREE_WR:
            begin
                state_next = ST_IDLE;
                rsp_load = 1'b1;
                head_idx = CW'(class_rd_reg);
                if (32'(class_rd_reg) < NUM_CLASSES)
                begin
                    head_we = 1'b1;
                    link_we = 1'b1;
                    head_wdata = HW'(cur_reg.slot[SW-1:0]) + HW'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bump_reg <= '0;
            head_ok_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (bump_we)
                bump_reg <= bump_reg + BW'(cur_reg.size32);
            if (head_we)
                head_ok_reg[head_idx] <= 1'b1;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // The head of the requested class is read while the command is captured.
    // A free reads its slot class first and the head of that class in the
    // following cycle, from the registered class.
    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= cmd;
        if (rsp_load)
            rsp_reg <= rsp_next;
        if (load)
            head_rd_reg <= heads_mem[CW'(cmd.cls)];
        else if (state_reg == ST_FREE_RD)
            head_rd_reg <= heads_mem[CW'(class_rd_reg)];
        if (state_reg == ST_READ)
            link_rd_reg <= link_mem[SW'(head_val - HW'(1))];
        class_rd_reg <= class_mem[slot_idx];
        if (head_we)
            heads_mem[head_idx] <= head_wdata;
        if (class_we)
            class_mem[SW'(bump_reg >> 4)] <= cur_reg.cls;
        if (link_we)
            link_mem[slot_idx] <= head_ok_reg[head_idx] ? head_rd_reg : '0;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload = rsp_reg;
endmodule
`default_nettype wire

>>> sv/size_class_free_list_allocator_core.sv
// Size-class free-list allocator. From request transfer to result, an
// oversize request or an ignored free needs no memory access; a bump carve or
// an exhausted heap takes a head read; a list pop takes a head read, then a
// link read and head write-back; a free takes a class read, a head read, then
// both writes. One item is in the back end at a time; the front register
// takes the next transfer meanwhile. Reset (asynchronous, active low) empties
// every class list, zeroes the bump offset and sets heap_limit to 65536.
`timescale 1ns / 1ps
`default_nettype none
module size_class_free_list_allocator_core #(
    parameter int HEAP_BYTES      = scfl_pkg::HEAP_BYTES_DEF,
    parameter int NUM_CLASSES     = scfl_pkg::NUM_CLASSES_DEF,
    parameter int HEADER_BYTES    = scfl_pkg::HEADER_BYTES_DEF,
    parameter int MAX_CLASS_BYTES = scfl_pkg::MAX_CLASS_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_wdata,
    scfl_req_if.sink         req,
    scfl_rsp_if.source       rsp
);
    import scfl_pkg::*;

    logic [16:0] heap_limit_reg;
    cmd_t        cmd;
    logic        cmd_valid;
    logic        cmd_ready;

    // The user must write the limit register only while idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            heap_limit_reg <= 17'd65536;
        else if (cfg_we)
            heap_limit_reg <= cfg_wdata;
    end

    // The front end classifies each transfer and holds it until the back
    // end takes it.
    scfl_front #(
        .HEAP_BYTES(HEAP_BYTES), .NUM_CLASSES(NUM_CLASSES),
        .HEADER_BYTES(HEADER_BYTES), .MAX_CLASS_BYTES(MAX_CLASS_BYTES)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
    );

    // The back end walks the lists and owns the result register.
    scfl_back #(
        .HEAP_BYTES(HEAP_BYTES), .NUM_CLASSES(NUM_CLASSES),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .heap_limit(heap_limit_reg),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .rsp(rsp)
    );

    // A result that is refused must not carry a data offset.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.status != STATUS_OK |-> rsp.payload.data_offset == 16'd0)
        else $error("error result with nonzero offset");

    // Status never takes the unused code.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.payload.status != 2'd3)
        else $error("bad status code");

    // A stalled command stays offered to the back end.
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid)
        else $error("command dropped");
endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the size-class free-list allocator core.
// Depends on scfl_pkg and the scfl_req_if / scfl_rsp_if interfaces.
`timescale 1ns / 1ps
module testbench;
    import scfl_pkg::*;

    localparam int PAD         = 16;
    localparam int SLOT_COUNT  = HEAP_BYTES_DEF / SLOT_BYTES;
    localparam int QUIET_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [16:0] cfg_wdata;

    scfl_req_if req_ch ();
    scfl_rsp_if rsp_ch ();

    size_class_free_list_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow copy of the allocator: the heap limit, the bump pointer, the
    // per-class list heads (slot + 1, zero for empty) and the per-slot class
    // and link stores.
    logic [16:0] heap_limit_q;
    logic [16:0] bump_q;
    logic [12:0] list_head [NUM_CLASSES_DEF];
    logic [7:0]  slot_class [SLOT_COUNT];
    logic [12:0] slot_link  [SLOT_COUNT];

    // Block starts that have been carved at least once. Only these may be
    // freed, since the class store of any other slot was never written.
    int unsigned carved_slots[$];

    rsp_t        expected_rsp[$];
    int          fail_count;
    int          quiet_cycles;
    bit          no_idle;

    always #5 clk = ~clk;

    // Work out the result of one accepted transfer and update the shadow state.
    function automatic rsp_t predict_alloc_free(input req_t item);
        rsp_t        r;
        int unsigned total;
        int unsigned cls;
        int unsigned size;
        int unsigned lim;
        int unsigned slot;
        int unsigned head;
        r = '0;
        r.status = STATUS_OK;
        if (item.func == FUNC_ALLOC) begin
            total = item.request_bytes + PAD;
            if (total > MAX_CLASS_BYTES_DEF) begin
                r.status = STATUS_OVERSIZE;
                return r;
            end
            cls = (total <= 16) ? 0 : (total + 31) / 32;
            if (cls >= NUM_CLASSES_DEF) begin
                r.status = STATUS_OVERSIZE;
                return r;
            end
            head = list_head[cls];
            if (head != 0 && head <= SLOT_COUNT) begin
                // Pop the class list.
                slot = head - 1;
                list_head[cls] = slot_link[slot];
            end
            else begin
                // Carve a fresh block at the bump pointer.
                size = (cls == 0) ? 16 : 32 * cls;
                lim  = (heap_limit_q > HEAP_BYTES_DEF) ? HEAP_BYTES_DEF : heap_limit_q;
                slot = bump_q / SLOT_BYTES;
                if (bump_q + size > lim || slot >= SLOT_COUNT) begin
                    r.status = STATUS_EXHAUSTED;
                    return r;
                end
                slot_class[slot] = cls[7:0];
                bump_q = 17'(bump_q + size);
                carved_slots.push_back(slot);
            end
            r.data_offset = 16'((slot * SLOT_BYTES + PAD) & 32'hFFFF);
        end
        else begin
            if (item.block_offset >= PAD) begin
                slot = (item.block_offset - PAD) / SLOT_BYTES;
                if (slot < SLOT_COUNT && slot_class[slot] < NUM_CLASSES_DEF) begin
                    cls = slot_class[slot];
                    slot_link[slot] = list_head[cls];
                    list_head[cls] = 13'(slot + 1);
                end
            end
        end
        return r;
    endfunction

    // Drive one transfer; valid stays high between back-to-back items.
    task automatic send_item(input req_t item);
        @(negedge clk);
        if (!no_idle && $urandom_range(99) < 20) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= item;
        do @(posedge clk); while (!req_ch.ready);
        expected_rsp.push_back(predict_alloc_free(item));
    endtask

    // Lower valid, wait until every result has come back, and then wait further
    // so that the back end is surely idle.
    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait (expected_rsp.size() == 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_heap_limit(input logic [16:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        heap_limit_q = value;
    endtask

    function automatic req_t make_alloc(input logic [15:0] bytes);
        req_t item;
        item.func          = FUNC_ALLOC;
        item.request_bytes = bytes;
        item.block_offset  = 16'($urandom);
        return item;
    endfunction

    function automatic req_t make_free(input logic [15:0] offset);
        req_t item;
        item.func          = FUNC_FREE;
        item.request_bytes = 16'($urandom);
        item.block_offset  = offset;
        return item;
    endfunction

    // Data offset of a carved block, with random low bits that the block
    // drops. The very last slot is skipped since its offset wraps to zero.
    function automatic logic [15:0] pick_carved_offset();
        int unsigned slot;
        int unsigned base;
        int unsigned low;
        do slot = carved_slots[$urandom_range(carved_slots.size() - 1)];
        while (slot >= SLOT_COUNT - 1);
        base = slot * SLOT_BYTES + PAD;
        low  = (65535 - base < 15) ? 65535 - base : 15;
        return 16'(base + $urandom_range(low));
    endfunction

    // Field extremes, the largest class, oversize requests, frees below the
    // pad, a double free and a free with stray low bits.
    task automatic test_directed();
        send_item(make_alloc(16'd0));
        send_item(make_alloc(16'd1));
        send_item(make_alloc(16'd16));
        send_item(make_alloc(16'd8080));
        send_item(make_alloc(16'd8081));
        send_item(make_alloc(16'hFFFF));
        send_item(make_free(16'd0));
        send_item(make_free(16'd15));
        send_item(make_free(16'd16));
        send_item(make_free(16'd16));
        send_item(make_alloc(16'd0));
        send_item(make_alloc(16'd0));
        send_item(make_free(16'd32 + 16'd15));
        send_item(make_alloc(16'd1));
        send_item(make_alloc(16'd200));
        send_item(make_free(16'd64));
        send_item(make_alloc(16'd8080));
    endtask

    // Tight limits: carving is refused while list pops and frees still work.
    task automatic test_heap_limit();
        write_heap_limit(17'd16);
        send_item(make_alloc(16'd0));
        send_item(make_alloc(16'd500));
        send_item(make_free(16'd64));
        send_item(make_alloc(16'd1));
        send_item(make_alloc(16'd1));
        write_heap_limit(17'h1FFFF);
        send_item(make_alloc(16'd100));
    endtask

    task automatic send_random_item();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 42 && carved_slots.size() != 0)
            send_item(make_free(pick_carved_offset()));
        else if (pick < 45)
            send_item(make_free(16'($urandom_range(15))));
        else if (pick < 80)
            send_item(make_alloc(16'($urandom_range(240))));
        else if (pick < 94)
            send_item(make_alloc(16'($urandom_range(8080))));
        else
            send_item(make_alloc(16'($urandom)));
    endtask

    // Random mix with limit changes, a no-idle stretch and a full drain.
    task automatic test_random();
        int n;
        for (n = 0; n < 1500; n++) begin
            if (n == 400)
                write_heap_limit(17'(bump_q + $urandom_range(64, 4096)));
            if (n == 700)
                write_heap_limit(17'd65536);
            if (n == 900)
                drain_results();
            no_idle = (n >= 1000 && n < 1250);
            send_random_item();
        end
        no_idle = 1'b0;
    endtask

    // Result drain side: stall at random except during the no-idle stretch.
    always @(negedge clk)
    begin
        rsp_ch.ready <= no_idle || ($urandom_range(99) >= 20);
    end

    // Compare every result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected result offset=%0d status=%0d", $time,
                         rsp_ch.payload.data_offset, rsp_ch.payload.status);
                fail_count++;
            end
            else begin
                if (rsp_ch.payload.data_offset !== expected_rsp[0].data_offset) begin
                    $display("%0t: data_offset mismatch expected=%0d actual=%0d", $time,
                             expected_rsp[0].data_offset, rsp_ch.payload.data_offset);
                    fail_count++;
                end
                if (rsp_ch.payload.status !== expected_rsp[0].status) begin
                    $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                             expected_rsp[0].status, rsp_ch.payload.status);
                    fail_count++;
                end
                void'(expected_rsp.pop_front());
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int i;
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        fail_count     = 0;
        quiet_cycles   = 0;
        no_idle        = 1'b0;
        heap_limit_q   = 17'd65536;
        bump_q         = '0;
        for (i = 0; i < NUM_CLASSES_DEF; i++)
            list_head[i] = '0;
        for (i = 0; i < SLOT_COUNT; i++) begin
            slot_class[i] = '0;
            slot_link[i]  = '0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_heap_limit();
        test_random();

        drain_results();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
